### rtl/oadf_pkg.sv
// package: item types, state codes, thresholds and speeds of the drive controller
package oadf_pkg;

  localparam int unsigned TickCounterWidth = 16;
  localparam int unsigned CfgWidth         = 16;
  localparam int unsigned CmpWidth         =
    (TickCounterWidth > CfgWidth) ? TickCounterWidth : CfgWidth;
  localparam int unsigned DistWidth        = 14;
  localparam int unsigned SpeedWidth       = 8;

  localparam logic [CfgWidth-1:0] WaitTicksReset = 16'd3000;

  // distances in q10.4 centimetres
  localparam logic [DistWidth-1:0] Cm15 = 14'd240;
  localparam logic [DistWidth-1:0] Cm20 = 14'd320;
  localparam logic [DistWidth-1:0] Cm30 = 14'd480;
  localparam logic [DistWidth-1:0] Cm40 = 14'd640;
  localparam logic [DistWidth-1:0] Cm60 = 14'd960;

  localparam logic signed [SpeedWidth-1:0] SpdZero   = 8'sd0;
  localparam logic signed [SpeedWidth-1:0] SpdSpin   = 8'sd15;
  localparam logic signed [SpeedWidth-1:0] SpdSpinN  = -8'sd15;
  localparam logic signed [SpeedWidth-1:0] SpdSlow   = 8'sd15;
  localparam logic signed [SpeedWidth-1:0] SpdSlight = 8'sd20;
  localparam logic signed [SpeedWidth-1:0] SpdFwd    = 8'sd20;
  localparam logic signed [SpeedWidth-1:0] SpdFast   = 8'sd25;
  localparam logic signed [SpeedWidth-1:0] SpdCruise = 8'sd27;
  localparam logic signed [SpeedWidth-1:0] SpdTurn   = 8'sd30;
  localparam logic signed [SpeedWidth-1:0] SpdHard   = 8'sd35;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_STEP = 1'b1
  } opcode_e;

  typedef enum logic [4:0] {
    ST_WAIT_A   = 5'd0,
    ST_WAIT_O   = 5'd1,
    ST_FWD_A    = 5'd2,
    ST_FWD_O    = 5'd3,
    ST_SLEFT_A  = 5'd4,
    ST_SLEFT_O  = 5'd5,
    ST_SRIGHT_A = 5'd6,
    ST_SRIGHT_O = 5'd7,
    ST_LEFT_A   = 5'd8,
    ST_LEFT_O   = 5'd9,
    ST_RIGHT_A  = 5'd10,
    ST_RIGHT_O  = 5'd11,
    ST_HLEFT_A  = 5'd12,
    ST_HLEFT_O  = 5'd13,
    ST_HRIGHT_A = 5'd14,
    ST_HRIGHT_O = 5'd15,
    ST_SPINL_A  = 5'd16,
    ST_SPINL_O  = 5'd17,
    ST_SPINR_A  = 5'd18,
    ST_SPINR_O  = 5'd19,
    ST_SLOW_A   = 5'd20,
    ST_SLOW_O   = 5'd21,
    ST_FAST_A   = 5'd22,
    ST_FAST_O   = 5'd23,
    ST_CRUISE_A = 5'd24,
    ST_CRUISE_O = 5'd25
  } state_e;

  typedef struct packed {
    logic                 opcode;
    logic [DistWidth-1:0] dist_right_outer;
    logic [DistWidth-1:0] dist_right;
    logic [DistWidth-1:0] dist_centre;
    logic [DistWidth-1:0] dist_left;
    logic [DistWidth-1:0] dist_left_outer;
  } in_item_t;

  typedef struct packed {
    logic [4:0]                   state_code;
    logic signed [SpeedWidth-1:0] right_speed;
    logic signed [SpeedWidth-1:0] left_speed;
  } out_item_t;

endpackage

### rtl/oadf_classifier.sv
// obstacle classifier: prioritized threshold compares picking the next action state
module oadf_classifier import oadf_pkg::*; (
  input  in_item_t item_i,
  input  logic     spin_parity_i,
  output state_e   action_o
);

  logic [DistWidth-1:0] ro, r, c, l, lo;

  assign ro = item_i.dist_right_outer;
  assign r  = item_i.dist_right;
  assign c  = item_i.dist_centre;
  assign l  = item_i.dist_left;
  assign lo = item_i.dist_left_outer;

  always_comb begin
    if (r < Cm15 && c > Cm20 && l > Cm15) begin
      action_o = ST_HRIGHT_A;
    end else if (r > Cm15 && c > Cm20 && l < Cm15) begin
      action_o = ST_HLEFT_A;
    end else if (r < Cm20 && c > Cm30 && l > Cm20) begin
      action_o = ST_RIGHT_A;
    end else if (r > Cm20 && c > Cm30 && l < Cm20) begin
      action_o = ST_LEFT_A;
    end else if (r < Cm30 && c > Cm40 && l > Cm30) begin
      action_o = ST_SRIGHT_A;
    end else if (r > Cm30 && c > Cm40 && l < Cm30) begin
      action_o = ST_SLEFT_A;
    end else if (c < Cm20) begin
      action_o = spin_parity_i ? ST_SPINL_A : ST_SPINR_A;
    end else if (c < Cm40) begin
      action_o = ST_SLOW_A;
    end else if (c < Cm60) begin
      action_o = ST_FWD_A;
    end else if (ro > lo) begin
      action_o = ST_SLEFT_A;
    end else if (ro < lo) begin
      action_o = ST_SRIGHT_A;
    end else begin
      action_o = ST_CRUISE_A;
    end
  end

endmodule

### rtl/oadf_core.sv
// controller state machine: state, wait counter, spin parity and motor registers
module oadf_core import oadf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  in_item_t            item_i,
  input  logic [CfgWidth-1:0] wait_ticks_i,
  output out_item_t           res_o
);

  localparam logic [TickCounterWidth-1:0] CntMax = {TickCounterWidth{1'b1}};

  state_e                        state_q, state_d, choice, own_action;
  logic [TickCounterWidth-1:0]   counter_q, counter_d;
  logic                          parity_q, parity_d;
  logic signed [SpeedWidth-1:0]  right_q, right_d, left_q, left_d;
  logic                          step, wait_done;

  assign step       = (item_i.opcode == OP_STEP);
  assign wait_done  = CmpWidth'(counter_q) > CmpWidth'(wait_ticks_i);
  assign own_action = state_e'(5'(state_q) - 5'd1);

  oadf_classifier u_classifier (
    .item_i        (item_i),
    .spin_parity_i (parity_q),
    .action_o      (choice)
  );

  // next state
  always_comb begin
    state_d = state_q;
    if (step) begin
      case (state_q)
        ST_WAIT_A:   state_d = ST_WAIT_O;
        ST_WAIT_O:   state_d = wait_done ? ST_FWD_A : ST_WAIT_O;
        ST_FWD_A:    state_d = ST_FWD_O;
        ST_SLEFT_A:  state_d = ST_SLEFT_O;
        ST_SRIGHT_A: state_d = ST_SRIGHT_O;
        ST_LEFT_A:   state_d = ST_LEFT_O;
        ST_RIGHT_A:  state_d = ST_RIGHT_O;
        ST_HLEFT_A:  state_d = ST_HLEFT_O;
        ST_HRIGHT_A: state_d = ST_HRIGHT_O;
        ST_SPINL_A:  state_d = ST_SPINL_O;
        ST_SPINR_A:  state_d = ST_SPINR_O;
        ST_SLOW_A:   state_d = ST_FWD_O;
        ST_FAST_A:   state_d = ST_FWD_O;
        ST_CRUISE_A: state_d = ST_CRUISE_O;
        ST_FWD_O, ST_SLEFT_O, ST_SRIGHT_O, ST_LEFT_O, ST_RIGHT_O, ST_HLEFT_O,
        ST_HRIGHT_O, ST_SPINL_O, ST_SPINR_O, ST_SLOW_O, ST_FAST_O,
        ST_CRUISE_O: state_d = (choice != own_action) ? choice : state_q;
        default:     state_d = ST_WAIT_A;
      endcase
    end
  end

  // motors, counter and parity
  always_comb begin
    right_d   = right_q;
    left_d    = left_q;
    parity_d  = parity_q;
    counter_d = counter_q;
    if (!step) begin
      if (counter_q != CntMax) begin
        counter_d = counter_q + 1'b1;
      end
    end else begin
      case (state_q)
        ST_WAIT_A: begin
          counter_d = '0;
          right_d   = SpdZero;
          left_d    = SpdZero;
        end
        ST_FWD_A: begin
          parity_d = ~parity_q;
          right_d  = SpdFwd;
          left_d   = SpdFwd;
        end
        ST_SLEFT_A:  begin right_d = SpdSlight; left_d = SpdZero;   end
        ST_SRIGHT_A: begin right_d = SpdZero;   left_d = SpdSlight; end
        ST_LEFT_A:   begin right_d = SpdTurn;   left_d = SpdZero;   end
        ST_RIGHT_A:  begin right_d = SpdZero;   left_d = SpdTurn;   end
        ST_HLEFT_A:  begin right_d = SpdHard;   left_d = SpdZero;   end
        ST_HRIGHT_A: begin right_d = SpdZero;   left_d = SpdHard;   end
        ST_SPINL_A:  begin right_d = SpdSpin;   left_d = SpdSpinN;  end
        ST_SPINR_A:  begin right_d = SpdSpinN;  left_d = SpdSpin;   end
        ST_SLOW_A:   begin right_d = SpdSlow;   left_d = SpdSlow;   end
        ST_FAST_A:   begin right_d = SpdFast;   left_d = SpdFast;   end
        ST_CRUISE_A: begin right_d = SpdCruise; left_d = SpdCruise; end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_WAIT_A;
      counter_q <= '0;
      parity_q  <= 1'b0;
      right_q   <= SpdZero;
      left_q    <= SpdZero;
    end else if (fire_i) begin
      state_q   <= state_d;
      counter_q <= counter_d;
      parity_q  <= parity_d;
      right_q   <= right_d;
      left_q    <= left_d;
    end
  end

  assign res_o.state_code  = 5'(state_d);
  assign res_o.right_speed = right_d;
  assign res_o.left_speed  = left_d;

  a_wait_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && step && state_q == ST_WAIT_A |=>
      state_q == ST_WAIT_O && counter_q == '0 && right_q == SpdZero && left_q == SpdZero)
    else $error("wait state did not clear counter and motors");

  a_tick_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !step |=> $stable(state_q) && $stable(right_q) && $stable(left_q))
    else $error("tick item changed state or motors");

  a_ongoing_keeps_motors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && step && state_q[0] |=> $stable(right_q) && $stable(left_q)
      && $stable(parity_q))
    else $error("ongoing state changed motors");

  a_counter_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !step && counter_q == CntMax |=> counter_q == CntMax)
    else $error("wait counter wrapped");

endmodule

### rtl/obstacle_avoidance_drive_fsm_unit.sv
// top level: input register, controller core, result register and config register
//
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o   in_item_i  (in_item_t)
// out      output     out_valid_o/out_stall_i out_item_o (out_item_t)
// cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (wait_ticks)
//
// one item per cycle sustained while out_stall_i is low;
// the core pass (threshold compares and next-state table) sits between the
// input register and the result register
// reset clears state, counter, parity and motors and sets wait_ticks to 3000
// a stalled result holds the result register and an occupied input register;
// cfg is always ready
module obstacle_avoidance_drive_fsm_unit import oadf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  logic                in_valid_q, out_valid_q, fire;
  in_item_t            in_item_q;
  out_item_t           out_item_q, res;
  logic [CfgWidth-1:0] wait_ticks_q;

  assign fire        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !fire;
  assign cfg_ready_o = 1'b1;

  oadf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (in_item_q),
    .wait_ticks_i (wait_ticks_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      wait_ticks_q <= WaitTicksReset;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        wait_ticks_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
